// ===== sv/dfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Damped comb filter package
// Shared constants, control types and saturation helper for the filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

   localparam int MAX_DELAY  = 4096;
   localparam int ADDR_W     = $clog2(MAX_DELAY);
   localparam int FILL_W     = ADDR_W + 1;
   localparam int DLEN_W     = 12;
   localparam int SAMPLE_W   = 16;
   localparam int FRAC_W     = 15;
   localparam int COEF_W     = SAMPLE_W + 1;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int ROUND_W    = SUM_W - FRAC_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DLEN_W-1:0]   DLEN_RESET = DLEN_W'(2048);
   localparam logic [SAMPLE_W-1:0] GAIN_RESET = SAMPLE_W'(24576);

   localparam logic signed [COEF_W-1:0] COEF_NEW = COEF_W'(6554);
   localparam logic signed [COEF_W-1:0] COEF_OLD = COEF_W'(26214);

   localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) <<< (FRAC_W - 1);

   typedef enum logic {
      REG_DELAY_LENGTH  = 1'b0,
      REG_FEEDBACK_GAIN = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic start;
      logic do_feedback;
      logic do_diff;
      logic do_new;
      logic commit;
   } dfc_ctl_type;

   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ROUND_W-1:0] v);
      logic signed [ROUND_W-1:0] hi;
      logic signed [ROUND_W-1:0] lo;
      hi = ROUND_W'(32767);
      lo = -ROUND_W'(32768);
      if (v > hi) begin
         sat16 = SAMPLE_W'(32767);
      end else if (v < lo) begin
         sat16 = SAMPLE_W'(16'h8000);
      end else begin
         sat16 = v[SAMPLE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/dfc_req_if.sv =====
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel that carries one input sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfc_req_if
   import dfc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== sv/dfc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Sample response channel
// Valid/ready channel that carries one delayed sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfc_rsp_if
   import dfc_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== sv/dfc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/dfc_csr.sv =====
// ----------------------------------------------------------------------------
// Filter configuration registers
// APB-style register file holding the delay length and the feedback gain.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_csr
   import dfc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready,
   output logic      [DLEN_W-1:0]      delay_length,
   output logic signed [SAMPLE_W-1:0]  feedback_gain
);

   logic [DLEN_W-1:0]   dlen_ff;
   logic [DLEN_W-1:0]   dlen_in;
   logic [SAMPLE_W-1:0] gain_ff;
   logic [SAMPLE_W-1:0] gain_in;
   logic                wr_stb;
   reg_index_type       reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel & penable & pwrite;
   assign reg_idx = reg_index_type'(paddr[2]);

   always_comb begin
      dlen_in = dlen_ff;
      gain_in = gain_ff;
      if (wr_stb) begin
         unique case (reg_idx)
            REG_DELAY_LENGTH:  dlen_in = pwdata[DLEN_W-1:0];
            REG_FEEDBACK_GAIN: gain_in = pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_DELAY_LENGTH:  prdata = CSR_DATA_W'(dlen_ff);
         REG_FEEDBACK_GAIN: prdata = CSR_DATA_W'(gain_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlen_ff <= DLEN_RESET;
         gain_ff <= GAIN_RESET;
      end else begin
         dlen_ff <= dlen_in;
         gain_ff <= gain_in;
      end
   end

   assign delay_length  = dlen_ff;
   assign feedback_gain = gain_ff;

endmodule

`default_nettype wire

// ===== sv/dfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Filter controller
// Sequences one sample through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_ctrl
   import dfc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output dfc_ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_FEEDBACK = 5'b00010,
      S_DIFF     = 5'b00100,
      S_NEW      = 5'b01000,
      S_MIX      = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.start = 1'b1;
               state_in  = S_FEEDBACK;
            end
         end
         S_FEEDBACK: begin
            ctl.do_feedback = 1'b1;
            state_in        = S_DIFF;
         end
         S_DIFF: begin
            ctl.do_diff = 1'b1;
            state_in    = S_NEW;
         end
         S_NEW: begin
            ctl.do_new = 1'b1;
            state_in   = S_MIX;
         end
         S_MIX: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== sv/dfc_datapath.sv =====
// ----------------------------------------------------------------------------
// Filter datapath
// Delay ring, shared multiplier, rounding and saturation, pointer and fill.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_datapath
   import dfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dfc_ctl_type           ctl,
   input  wire logic signed [SAMPLE_W-1:0] sample_in,
   input  wire logic [DLEN_W-1:0]     delay_length,
   input  wire logic signed [SAMPLE_W-1:0] feedback_gain,
   output logic signed [SAMPLE_W-1:0] sample_out
);

   logic [ADDR_W-1:0]          ptr_ff;
   logic [ADDR_W-1:0]          ptr_in;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic signed [SAMPLE_W-1:0] prev_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic                       rd_valid_ff;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] diff_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [PROD_W-1:0]   prod_old_ff;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic [SAMPLE_W-1:0]          ram_q;
   logic signed [SAMPLE_W-1:0]   rd_val;
   logic signed [COEF_W-1:0]     mul_a;
   logic signed [SAMPLE_W-1:0]   mul_b;
   logic signed [COEF_W+SAMPLE_W-1:0] mul_p;
   logic signed [SUM_W-1:0]      diff_sum;
   logic signed [SUM_W-1:0]      mix_sum;
   logic signed [SAMPLE_W-1:0]   diff_sat;
   logic signed [SAMPLE_W-1:0]   stored;
   logic [FILL_W-1:0]            len_eff;
   logic [FILL_W-1:0]            dlen_ext;
   logic [FILL_W-1:0]            ptr_inc;

   dfc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_DELAY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ctl.commit),
      .wr_addr (ptr_ff),
      .wr_data (stored),
      .rd_en   (ctl.start),
      .rd_addr (ptr_ff),
      .rd_data (ram_q)
   );

   assign rd_val = rd_valid_ff ? $signed(ram_q) : '0;

   always_comb begin
      if (ctl.start) begin
         mul_a = COEF_OLD;
         mul_b = prev_ff;
      end else if (ctl.do_feedback) begin
         mul_a = {feedback_gain[SAMPLE_W-1], feedback_gain};
         mul_b = rd_val;
      end else begin
         mul_a = COEF_NEW;
         mul_b = diff_ff;
      end
   end

   assign mul_p = mul_a * mul_b;

   assign diff_sum = ({{(SUM_W-SAMPLE_W-FRAC_W){x_ff[SAMPLE_W-1]}}, x_ff, {FRAC_W{1'b0}}}
                      - {prod_ff[PROD_W-1], prod_ff}) + ROUND_BIAS;
   assign diff_sat = sat16(diff_sum[SUM_W-1:FRAC_W]);

   assign mix_sum = {prod_ff[PROD_W-1], prod_ff} + {prod_old_ff[PROD_W-1], prod_old_ff}
                    + ROUND_BIAS;
   assign stored  = sat16(mix_sum[SUM_W-1:FRAC_W]);

   assign dlen_ext = FILL_W'(delay_length);

   always_comb begin
      if (dlen_ext == '0) begin
         len_eff = FILL_W'(1);
      end else if (dlen_ext >= FILL_W'(MAX_DELAY)) begin
         len_eff = FILL_W'(MAX_DELAY - 1);
      end else begin
         len_eff = dlen_ext;
      end
   end

   assign ptr_inc = {1'b0, ptr_ff} + FILL_W'(1);

   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (ctl.commit) begin
         ptr_in = (ptr_inc >= len_eff) ? '0 : ptr_inc[ADDR_W-1:0];
         if (ptr_inc > fill_ff) begin
            fill_in = ptr_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
         prev_ff <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         if (ctl.commit) begin
            prev_ff <= stored;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x_ff        <= sample_in;
         rd_valid_ff <= ({1'b0, ptr_ff} < fill_ff);
         prod_old_ff <= mul_p[PROD_W-1:0];
      end
      if (ctl.do_feedback) begin
         rd_ff   <= rd_val;
         prod_ff <= mul_p[PROD_W-1:0];
      end
      if (ctl.do_diff) begin
         diff_ff <= diff_sat;
      end
      if (ctl.do_new) begin
         prod_ff <= mul_p[PROD_W-1:0];
      end
      if (ctl.commit) begin
         out_ff <= rd_ff;
      end
   end

   assign sample_out = out_ff;

endmodule

`default_nettype wire

// ===== sv/damped_feedback_comb_filter_core.sv =====
// ----------------------------------------------------------------------------
// Damped feedback comb filter core
// Comb filter with a one-pole lowpass in its feedback loop, Q1.15 samples.
//
// Usage:
//   req carries one signed Q1.15 sample per transfer; rsp returns one signed
//   Q1.15 sample per transfer, the ring value read before the write-back.
//   Registers sit on the APB-style port: delay_length at byte 0, feedback_gain
//   at byte 4. Write them only while no sample is in flight.
//   A sample passes the feedback, difference, new and mix states before its
//   result shows on rsp; the core takes a new sample only after the last one
//   is written back. The pace is set by the single shared 17x16 multiplier,
//   used three times per sample, plus the ring read and rounding around it.
//   The result sits in an output register; while it waits the core still
//   takes the next sample and holds that one's write-back until the output
//   register frees up.
//   Reset sets the registers to their defaults and clears the pointer, the
//   lowpass state and the ring fill count; ring slots not yet written read
//   as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_feedback_comb_filter_core
   import dfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   dfc_req_if.sink                    req,
   dfc_rsp_if.source                  rsp,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   dfc_ctl_type                ctl;
   logic [DLEN_W-1:0]          delay_length;
   logic signed [SAMPLE_W-1:0] feedback_gain;

   dfc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .delay_length  (delay_length),
      .feedback_gain (feedback_gain)
   );

   dfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .ctl       (ctl)
   );

   dfc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sample_in     (req.sample_in),
      .delay_length  (delay_length),
      .feedback_gain (feedback_gain),
      .sample_out    (rsp.sample_out)
   );

endmodule

`default_nettype wire
